/* rtl/sorted_insertion_queue_defines.svh */
// ----------------------------------------------------------------------------
// Sorted insertion queue assertion macros
// Concurrent check wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERTION_QUEUE_DEFINES_SVH
`define SORTED_INSERTION_QUEUE_DEFINES_SVH
`ifndef SYNTH
`define SIQ_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SIQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SIQ_ASSERT(label, expr, msg)
`define SIQ_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

/* rtl/sortq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted insertion queue package
// Sizes, command and status codes and shared types.
// ----------------------------------------------------------------------------
package sortq_pkg;

    localparam int CAPACITY = 64;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int LANES    = 8;
    localparam int NG       = (CAPACITY + LANES - 1) / LANES;

    typedef logic signed [31:0] value_t;
    typedef logic [CW-1:0]      count_t;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_POP_FRONT = 3'd1,
        CMD_POP_BACK  = 3'd2,
        CMD_READ      = 3'd3,
        CMD_CLEAR     = 3'd4
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    typedef struct packed {
        logic insert;
        logic pop_front;
    } cell_op_t;

endpackage

/* rtl/sortq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted insertion queue cell
// Holds one entry; shifts right on insert past it, left on pop front.
// ----------------------------------------------------------------------------
module sortq_cell
(
    input  logic               clk,
    input  sortq_pkg::cell_op_t op,
    input  sortq_pkg::value_t  ins_value,
    input  logic               valid,
    input  logic               at_end,
    input  logic               left_gt,
    input  sortq_pkg::value_t  left_value,
    input  sortq_pkg::value_t  right_value,
    output logic               gt,
    output sortq_pkg::value_t  value
);

    sortq_pkg::value_t value_reg;
    sortq_pkg::value_t value_next;

    assign gt    = valid && (value_reg > ins_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (op.insert)
        begin
            if (left_gt)
            begin
                value_next = left_value;
            end
            else if (gt || at_end)
            begin
                value_next = ins_value;
            end
        end
        else if (op.pop_front)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* rtl/sortq_rdmux.sv */
// ----------------------------------------------------------------------------
// Sorted insertion queue read mux
// Two-level select of one cell value: lane pick registered, then group pick.
// ----------------------------------------------------------------------------
module sortq_rdmux
(
    input  logic                clk,
    input  logic                load,
    input  sortq_pkg::count_t   sel,
    input  sortq_pkg::value_t   cells [sortq_pkg::CAPACITY],
    output sortq_pkg::value_t   data
);

    localparam int GW = sortq_pkg::CW;
    localparam int LW = $clog2(sortq_pkg::LANES);

    logic [GW+LW-1:0]  sel_ext;
    logic [LW-1:0]     lane;
    logic [GW-1:0]     grp_reg;
    sortq_pkg::value_t pick     [sortq_pkg::NG][sortq_pkg::LANES];
    sortq_pkg::value_t cand     [sortq_pkg::NG];
    sortq_pkg::value_t cand_reg [sortq_pkg::NG];

    assign sel_ext = (GW+LW)'(sel);
    assign lane    = sel_ext[LW-1:0];

    for (genvar g = 0; g < sortq_pkg::NG; g++)
    begin : g_grp
        for (genvar l = 0; l < sortq_pkg::LANES; l++)
        begin : g_lane
            if (g * sortq_pkg::LANES + l < sortq_pkg::CAPACITY)
            begin : g_cell
                assign pick[g][l] = cells[g * sortq_pkg::LANES + l];
            end
            else
            begin : g_pad
                assign pick[g][l] = '0;
            end
        end
        assign cand[g] = pick[g][lane];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg  <= sel_ext[GW+LW-1:LW];
            cand_reg <= cand;
        end
    end

    always_comb
    begin
        data = '0;
        for (int g = 0; g < sortq_pkg::NG; g++)
        begin
            if (grp_reg == GW'(g))
            begin
                data = cand_reg[g];
            end
        end
    end

endmodule

/* rtl/sorted_insertion_queue.sv */
// ----------------------------------------------------------------------------
// Sorted insertion queue
// Ascending store of signed values built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Commands enter on the s_ stream, one result per command leaves on m_.
// Insert, remove smallest, remove largest, read at position and clear.
// Each item passes the accept step in S_IDLE, then S_EXEC, in which every
// cell compares and shifts at once and the first read-mux level is
// registered, then S_FIN, the group select into the output register.
// s_tready is high only while no command is in work, so a new item is
// taken only once the last one has left S_FIN for the output register.
// The output register parts the two sides: a new item is taken while a
// result still waits; if m_tready is held low the next result stays in
// the last step and no further item is accepted until the slot frees.
// Reset empties the store (count to zero) and drops any pending result;
// entry contents are not cleared, only positions below the count are read.
// ----------------------------------------------------------------------------
`include "sorted_insertion_queue_defines.svh"

module sorted_insertion_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[2:0], value[34:3], position[40:35], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_value[31:0], status[33:32], count[40:34], zero
);

    localparam int CAP = sortq_pkg::CAPACITY;

    sortq_pkg::state_t  state_reg;
    sortq_pkg::state_t  state_next;
    sortq_pkg::count_t  count_reg;
    sortq_pkg::count_t  count_next;
    logic [2:0]         cmd_reg;
    sortq_pkg::value_t  val_reg;
    logic [5:0]         pos_reg;
    sortq_pkg::status_t status_reg;
    sortq_pkg::status_t status_next;
    logic               use_read_reg;
    logic               use_read_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    sortq_pkg::value_t  res_reg;
    sortq_pkg::status_t res_status_reg;
    sortq_pkg::count_t  res_count_reg;
    logic               out_load;
    logic               rd_load;
    sortq_pkg::count_t  rd_sel;
    sortq_pkg::value_t  rd_data;
    sortq_pkg::cell_op_t op;
    sortq_pkg::value_t  cell_value [CAP];
    logic               cell_gt    [CAP];

    assign s_tready = (state_reg == sortq_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, 7'(res_count_reg), res_status_reg, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sortq_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tdata[2:0];
            val_reg <= s_tdata[34:3];
            pos_reg <= s_tdata[40:35];
        end
        if (state_reg == sortq_pkg::S_EXEC)
        begin
            status_reg   <= status_next;
            use_read_reg <= use_read_next;
        end
        if (out_load)
        begin
            res_reg        <= use_read_reg ? rd_data : '0;
            res_status_reg <= status_reg;
            res_count_reg  <= count_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        status_next   = sortq_pkg::ST_OK;
        use_read_next = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_load      = 1'b0;
        rd_load       = 1'b0;
        rd_sel        = '0;
        op            = '0;
        case (state_reg)
            sortq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sortq_pkg::S_EXEC;
                end
            end
            sortq_pkg::S_EXEC:
            begin
                rd_load    = 1'b1;
                state_next = sortq_pkg::S_FIN;
                case (cmd_reg)
                    sortq_pkg::CMD_INSERT:
                    begin
                        if (count_reg == sortq_pkg::CW'(CAP))
                        begin
                            status_next = sortq_pkg::ST_FULL;
                        end
                        else
                        begin
                            op.insert  = 1'b1;
                            count_next = count_reg + sortq_pkg::CW'(1);
                        end
                    end
                    sortq_pkg::CMD_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = sortq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            op.pop_front  = 1'b1;
                            use_read_next = 1'b1;
                            count_next    = count_reg - sortq_pkg::CW'(1);
                        end
                    end
                    sortq_pkg::CMD_POP_BACK:
                    begin
                        rd_sel = count_reg - sortq_pkg::CW'(1);
                        if (count_reg == '0)
                        begin
                            status_next = sortq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            use_read_next = 1'b1;
                            count_next    = count_reg - sortq_pkg::CW'(1);
                        end
                    end
                    sortq_pkg::CMD_READ:
                    begin
                        rd_sel = sortq_pkg::CW'(pos_reg);
                        if (32'(pos_reg) >= 32'(count_reg))
                        begin
                            status_next = sortq_pkg::ST_RANGE;
                        end
                        else
                        begin
                            use_read_next = 1'b1;
                        end
                    end
                    sortq_pkg::CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sortq_pkg::S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = sortq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sortq_pkg::S_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic              left_gt;
        sortq_pkg::value_t left_value;
        sortq_pkg::value_t right_value;

        if (i == 0)
        begin : g_first
            assign left_gt    = 1'b0;
            assign left_value = '0;
        end
        else
        begin : g_mid
            assign left_gt    = cell_gt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        sortq_cell u_cell
        (
            .clk         (clk),
            .op          (op),
            .ins_value   (val_reg),
            .valid       (count_reg > sortq_pkg::CW'(i)),
            .at_end      (count_reg == sortq_pkg::CW'(i)),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .right_value (right_value),
            .gt          (cell_gt[i]),
            .value       (cell_value[i])
        );
    end

    sortq_rdmux u_rdmux
    (
        .clk   (clk),
        .load  (rd_load),
        .sel   (rd_sel),
        .cells (cell_value),
        .data  (rd_data)
    );

    `SIQ_ASSERT(a_count_cap, count_reg <= sortq_pkg::CW'(CAP), "count above capacity")
    `SIQ_ASSERT_IMP(a_full_count, m_tvalid && (m_tdata[33:32] == sortq_pkg::ST_FULL),
        res_count_reg == sortq_pkg::CW'(CAP), "full reported below capacity")
    `SIQ_ASSERT_IMP(a_empty_count, m_tvalid && (m_tdata[33:32] == sortq_pkg::ST_EMPTY),
        res_count_reg == '0, "empty reported with entries stored")
    `SIQ_ASSERT_IMP(a_err_zero, m_tvalid && (m_tdata[33:32] != sortq_pkg::ST_OK),
        m_tdata[31:0] == 32'd0, "nonzero value with error status")
    `SIQ_ASSERT_IMP(a_fin_order, state_reg == sortq_pkg::S_FIN,
        $past(state_reg) == sortq_pkg::S_EXEC || $past(state_reg) == sortq_pkg::S_FIN,
        "result step not preceded by execute")

endmodule

/* tb/tb_sorted_insertion_queue.sv */
// ----------------------------------------------------------------------------
// Sorted insertion queue testbench
// Sends insert, remove smallest, remove largest, read-at-position, clear and
// unused command items on the input stream. A sorted store kept in the bench
// predicts each result, and every result is compared field by field. Covers
// the empty, full, single-element and out-of-range cases, then random traffic
// with idle and stall on both sides.
// ----------------------------------------------------------------------------
module tb_sorted_insertion_queue;

    import sortq_pkg::*;

    localparam logic [2:0] CMD_LAST_CODE = 3'd7;

    typedef struct {
        value_t  value;
        status_t status;
        count_t  count;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    value_t sorted_store[$];
    reply_t pending_replies[$];
    int     send_idle_pct = 0;
    int     sink_stall_pct = 0;
    int     error_count = 0;

    sorted_insertion_queue dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1000000;
        $display("tb_sorted_insertion_queue: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // apply one command to the bench's sorted store, return the expected result
    function automatic reply_t apply_command(logic [2:0] cmd, value_t val, logic [5:0] pos);
        reply_t r;
        int     slot;
        r.value  = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT:
            begin
                if (sorted_store.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    slot = 0;
                    while (slot < sorted_store.size() && sorted_store[slot] <= val)
                        slot++;
                    sorted_store.insert(slot, val);
                end
            end
            CMD_POP_FRONT:
            begin
                if (sorted_store.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = sorted_store.pop_front();
            end
            CMD_POP_BACK:
            begin
                if (sorted_store.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = sorted_store.pop_back();
            end
            CMD_READ:
            begin
                if (pos >= sorted_store.size())
                    r.status = ST_RANGE;
                else
                    r.value = sorted_store[pos];
            end
            CMD_CLEAR:
                sorted_store.delete();
            default:
                ;
        endcase
        r.count = count_t'(sorted_store.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result item with nothing expected: %h", m_tdata);
                error_count++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (value_t'(m_tdata[31:0]) !== exp_r.value)
                begin
                    $error("result_value expected %0d actual %0d",
                           exp_r.value, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[33:32] !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, m_tdata[33:32]);
                    error_count++;
                end
                if (m_tdata[40:34] !== exp_r.count)
                begin
                    $error("count expected %0d actual %0d", exp_r.count, m_tdata[40:34]);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(logic [2:0] cmd, value_t val, logic [5:0] pos);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pos, val, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_replies.push_back(apply_command(cmd, val, pos));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic value_t pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return value_t'($urandom());
        else if (roll < 80)
            return value_t'($signed($urandom_range(0, 16)) - 8);
        else if (roll < 90)
            return 32'sh7fff_ffff - value_t'($urandom_range(0, 2));
        else
            return 32'sh8000_0000 + value_t'($urandom_range(0, 2));
    endfunction

    task automatic test_directed();
        int c;
        send_item(CMD_POP_FRONT, '0, '0);
        send_item(CMD_POP_BACK, '0, '0);
        send_item(CMD_READ, '0, '0);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_INSERT, 32'sd0, '0);
        send_item(CMD_POP_FRONT, '0, '0);          // only element out from front
        send_item(CMD_INSERT, 32'sh7fff_ffff, '0);
        send_item(CMD_POP_BACK, '0, '0);           // only element out from back
        send_item(CMD_INSERT, 32'sh8000_0000, 6'd63);
        send_item(CMD_INSERT, 32'sh7fff_ffff, 6'd63);
        send_item(CMD_INSERT, -32'sd1, '0);
        send_item(CMD_INSERT, -32'sd1, '0);
        send_item(CMD_INSERT, 32'sd0, '0);
        send_item(CMD_READ, 32'sh7fff_ffff, 6'd0);
        send_item(CMD_READ, '0, 6'd4);
        send_item(CMD_READ, '0, 6'd5);
        send_item(CMD_READ, '0, 6'd63);
        for (c = CMD_CLEAR + 1; c <= CMD_LAST_CODE; c++)
            send_item(c[2:0], 32'sh8000_0000 | value_t'($urandom()), 6'h3f);
        send_item(CMD_POP_FRONT, '0, '0);
        send_item(CMD_POP_BACK, '0, '0);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_READ, '0, '0);
    endtask

    task automatic test_full_store();
        int i;
        send_item(CMD_CLEAR, '0, '0);
        for (i = 0; i < CAPACITY; i++)
            send_item(CMD_INSERT, pick_value(), 6'($urandom()));
        send_item(CMD_INSERT, pick_value(), '0);
        send_item(CMD_INSERT, 32'sh8000_0000, '0);
        for (i = 0; i < CAPACITY; i++)
            send_item(CMD_READ, value_t'($urandom()), i[5:0]);
        for (i = 0; i < CAPACITY; i++)
            send_item((i % 2) ? CMD_POP_BACK : CMD_POP_FRONT, '0, '0);
        send_item(CMD_POP_FRONT, '0, '0);
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct, bit drain_midway);
        int         i;
        int         roll;
        int         insert_pct;
        logic [2:0] cmd;
        logic [5:0] pos;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        for (i = 0; i < n; i++)
        begin
            if (drain_midway && i == n / 2)
                wait_drained();
            // alternate fill-heavy and drain-heavy stretches
            insert_pct = ((i / 40) % 2 == 0) ? 62 : 22;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                cmd = CMD_CLEAR;
            else if (roll < 5)
                cmd = 3'($urandom_range(CMD_CLEAR + 1, CMD_LAST_CODE));
            else if (roll < 5 + insert_pct)
                cmd = CMD_INSERT;
            else if (roll % 3 == 0)
                cmd = CMD_POP_FRONT;
            else if (roll % 3 == 1)
                cmd = CMD_POP_BACK;
            else
                cmd = CMD_READ;
            if (sorted_store.size() > 0 && $urandom_range(0, 3) != 0)
                pos = 6'($urandom_range(0, sorted_store.size() - 1));
            else
                pos = 6'($urandom());
            send_item(cmd, pick_value(), pos);
        end
    endtask

    initial
    begin
        send_idle_pct  = 22;
        sink_stall_pct = 48;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_store();
        test_random(110, 22, 48, 1'b1);
        test_random(110, 48, 22, 1'b0);
        test_random(110, 0, 0, 1'b0);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("tb_sorted_insertion_queue: done, clean");
        else
            $display("tb_sorted_insertion_queue: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sortq_pkg.sv
rtl/sortq_cell.sv
rtl/sortq_rdmux.sv
rtl/sorted_insertion_queue.sv
tb/tb_sorted_insertion_queue.sv
